FILE: src/fat12fs_pkg.sv
`default_nettype none

package fat12fs_pkg;

  // Stream offset counter and FAT entry widths
  localparam int unsigned OffsetBits = 21;
  localparam int unsigned EntryBits  = 12;

  localparam logic [OffsetBits-1:0] OffsetMax     = {OffsetBits{1'b1}};
  localparam logic [EntryBits-1:0]  EntryMax      = {EntryBits{1'b1}};
  localparam logic [EntryBits-1:0]  EntryLastPair = EntryMax - 1'b1;

  // Boot sector byte offsets (BPB fields used by the scan)
  localparam logic [4:0] OffBpsLo  = 5'd11;
  localparam logic [4:0] OffBpsHi  = 5'd12;
  localparam logic [4:0] OffRsvLo  = 5'd14;
  localparam logic [4:0] OffRsvHi  = 5'd15;
  localparam logic [4:0] OffNfat   = 5'd16;
  localparam logic [4:0] OffRentLo = 5'd17;
  localparam logic [4:0] OffRentHi = 5'd18;
  localparam logic [4:0] OffScLo   = 5'd19;
  localparam logic [4:0] OffScHi   = 5'd20;
  localparam logic [4:0] OffSpfLo  = 5'd22;
  localparam logic [4:0] OffSpfHi  = 5'd23;

  // Last boot byte, and the first offset the FAT may occupy
  localparam int unsigned BootEndOffset = 23;
  localparam int unsigned FatMinOffset  = 24;

  // Root directory size divider: entries times 32 over bytes per sector
  localparam int unsigned RootShift = 5;
  localparam int unsigned DivBits   = 16 + RootShift;
  localparam int unsigned DivCntW   = $clog2(DivBits + 1);

  // Position inside a three-byte pair of 12-bit entries
  typedef enum logic [1:0] {
    PhFirst,
    PhSecond,
    PhThird,
    PhDone
  } phase_e;

  // Datapath operation selected by one control word
  typedef enum logic [3:0] {
    OpNone,
    OpByte,
    OpFatStart,
    OpRoot,
    OpDivInit,
    OpDivStep,
    OpData,
    OpHi,
    OpEmit
  } op_e;

  // Stall conditions: stay on the step while true, datapath op suppressed
  typedef enum logic [1:0] {
    HoldNone,
    HoldInput,
    HoldOutput
  } hold_e;

  // Branch conditions: go to target when true, else fall through
  typedef enum logic [2:0] {
    JmpNever,
    JmpAlways,
    JmpPlain,
    JmpNoDerive,
    JmpDivMore,
    JmpNotLast
  } jump_e;

  localparam int unsigned StepW = 4;

  localparam logic [StepW-1:0] StepFetch    = 4'd0;
  localparam logic [StepW-1:0] StepRoute    = 4'd1;
  localparam logic [StepW-1:0] StepFatStart = 4'd2;
  localparam logic [StepW-1:0] StepRoot     = 4'd3;
  localparam logic [StepW-1:0] StepDivInit  = 4'd4;
  localparam logic [StepW-1:0] StepDivStep  = 4'd5;
  localparam logic [StepW-1:0] StepData     = 4'd6;
  localparam logic [StepW-1:0] StepHi       = 4'd7;
  localparam logic [StepW-1:0] StepLastChk  = 4'd8;
  localparam logic [StepW-1:0] StepEmit     = 4'd9;

  typedef struct packed {
    logic             accept;
    op_e              op;
    hold_e            hold;
    jump_e            jump;
    logic [StepW-1:0] target;
  } ucode_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] pc);
    ucode_t cw;
    cw = '{1'b0, OpNone, HoldNone, JmpAlways, StepFetch};
    unique case (pc)
      StepFetch:    cw = '{1'b1, OpByte,     HoldInput,  JmpPlain,    StepFetch};
      StepRoute:    cw = '{1'b0, OpNone,     HoldNone,   JmpNoDerive, StepLastChk};
      StepFatStart: cw = '{1'b0, OpFatStart, HoldNone,   JmpNever,    StepFetch};
      StepRoot:     cw = '{1'b0, OpRoot,     HoldNone,   JmpNever,    StepFetch};
      StepDivInit:  cw = '{1'b0, OpDivInit,  HoldNone,   JmpNever,    StepFetch};
      StepDivStep:  cw = '{1'b0, OpDivStep,  HoldNone,   JmpDivMore,  StepDivStep};
      StepData:     cw = '{1'b0, OpData,     HoldNone,   JmpNever,    StepFetch};
      StepHi:       cw = '{1'b0, OpHi,       HoldNone,   JmpNever,    StepFetch};
      StepLastChk:  cw = '{1'b0, OpNone,     HoldNone,   JmpNotLast,  StepFetch};
      StepEmit:     cw = '{1'b0, OpEmit,     HoldOutput, JmpAlways,   StepFetch};
      default:      cw = '{1'b0, OpNone,     HoldNone,   JmpAlways,   StepFetch};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

FILE: src/fat12_free_space_scan_top.sv
// FAT12 free space scanner. Feed the disk image one byte per transfer from
// offset 0 and mark the final byte with last_byte_i; one result follows it.
// Ordinary bytes are taken at one per cycle. After boot byte 23 the input
// stalls while the geometry is derived: a shared 16x16 multiplier forms the
// FAT start, the root start and later the free byte count, and a bit-serial
// divider forms root entries times 32 over bytes per sector. After the last
// byte the route and last-check steps run before the emit step loads the result
// register. The block is run by a ten-step microcode table; the result register
// lets the next image start streaming while a result waits, and a new result
// waits for the previous one to be taken.
`default_nettype none

module fat12_free_space_scan_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  image_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [27:0]      free_bytes_o,
  output logic [11:0]      free_clusters_o,
  output logic [15:0]      sector_size_o,
  output logic [23:0]      root_start_sector_o,
  output logic [23:0]      data_start_sector_o,
  output logic             geometry_error_o
);
  import fat12fs_pkg::*;

  // Sequencer
  logic [StepW-1:0] pc_q, pc_d;
  ucode_t           cw;
  logic             hold_hit, jump_hit, go;

  // Stream and boot fields
  logic [OffsetBits-1:0] off_q, off_d;
  logic [15:0] bps_q, bps_d, rsv_q, rsv_d, rent_q, rent_d;
  logic [15:0] sc_q, sc_d, spf_q, spf_d;
  logic [7:0]  nfat_q, nfat_d;
  logic        last_q, last_d;

  // Derived geometry
  logic [31:0] fat_start_q, fat_start_d;
  logic        fat_ok_q, fat_ok_d;
  logic [23:0] root_q, root_d, data_q, data_d;
  logic [EntryBits-1:0] hi_q, hi_d;

  // FAT unpacking
  phase_e               phase_q, phase_d;
  logic [7:0]           held_q, held_d;
  logic [EntryBits-1:0] entry_q, entry_d, free_q, free_d;
  logic                 ent_chk;
  logic [EntryBits-1:0] ent_val, ent_idx;

  // Divider
  logic [DivBits-1:0] div_q, div_d;
  logic [15:0]        rem_q, rem_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic [16:0]        trial;
  logic               qbit;

  // Shared multiplier and scratch
  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic [24:0] data_sum;
  logic [16:0] hi_diff;
  logic [EntryBits:0] next_ent;
  logic        err;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [27:0] res_bytes_q, res_bytes_d;
  logic [11:0] res_free_q, res_free_d;
  logic [15:0] res_bps_q, res_bps_d;
  logic [23:0] res_root_q, res_root_d, res_data_q, res_data_d;
  logic        res_err_q, res_err_d;

  assign cw = ucode_rom(pc_q);

  // Pick multiplier operands for the active step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cw.op)
      OpFatStart: begin
        mul_a = bps_q;
        mul_b = rsv_q;
      end
      OpRoot: begin
        mul_a = {8'b0, nfat_q};
        mul_b = spf_q;
      end
      OpEmit: begin
        mul_a = {4'b0, free_q};
        mul_b = bps_q;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Evaluate stall and branch conditions
  always_comb begin
    unique case (cw.hold)
      HoldInput:  hold_hit = !in_valid_i;
      HoldOutput: hold_hit = out_valid_q && !out_ready_i;
      default:    hold_hit = 1'b0;
    endcase
    unique case (cw.jump)
      JmpAlways:   jump_hit = 1'b1;
      JmpPlain:    jump_hit = !last_byte_i && (off_q != OffsetBits'(BootEndOffset));
      JmpNoDerive: jump_hit = off_q != OffsetBits'(FatMinOffset);
      JmpDivMore:  jump_hit = dcnt_q != DivCntW'(1);
      JmpNotLast:  jump_hit = !last_q;
      default:     jump_hit = 1'b0;
    endcase
    go = !hold_hit;
    if (hold_hit) begin
      pc_d = pc_q;
    end else if (jump_hit) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // Datapath next state
  always_comb begin
    off_d       = off_q;
    bps_d       = bps_q;
    rsv_d       = rsv_q;
    nfat_d      = nfat_q;
    rent_d      = rent_q;
    sc_d        = sc_q;
    spf_d       = spf_q;
    last_d      = last_q;
    fat_start_d = fat_start_q;
    fat_ok_d    = fat_ok_q;
    root_d      = root_q;
    data_d      = data_q;
    hi_d        = hi_q;
    phase_d     = phase_q;
    held_d      = held_q;
    entry_d     = entry_q;
    free_d      = free_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    ent_chk     = 1'b0;
    ent_val     = '0;
    ent_idx     = '0;
    trial       = {rem_q, div_q[DivBits-1]};
    qbit        = trial >= {1'b0, bps_q};
    data_sum    = {1'b0, root_q} + 25'((bps_q == '0) ? '0 : div_q);
    hi_diff     = 17'(sc_q) - 17'(data_q[15:0]) + 17'd1;
    next_ent    = {1'b0, entry_q} + {{EntryBits{1'b0}}, phase_q == PhThird};
    err         = (off_q < OffsetBits'(FatMinOffset)) || !fat_ok_q ||
                  ((hi_q >= EntryBits'(2)) && (phase_q != PhDone) &&
                   (next_ent <= {1'b0, hi_q}));
    out_valid_d = out_valid_q && !out_ready_i;
    res_bytes_d = res_bytes_q;
    res_free_d  = res_free_q;
    res_bps_d   = res_bps_q;
    res_root_d  = res_root_q;
    res_data_d  = res_data_q;
    res_err_d   = res_err_q;

    unique case (cw.op)
      // Take one image byte: boot field capture or FAT unpack
      OpByte: if (go) begin
        last_d = last_byte_i;
        if (off_q != OffsetMax) begin
          off_d = off_q + 1'b1;
          if (off_q < OffsetBits'(FatMinOffset)) begin
            unique case (off_q[4:0])
              OffBpsLo:  bps_d[7:0]   = image_byte_i;
              OffBpsHi:  bps_d[15:8]  = image_byte_i;
              OffRsvLo:  rsv_d[7:0]   = image_byte_i;
              OffRsvHi:  rsv_d[15:8]  = image_byte_i;
              OffNfat:   nfat_d       = image_byte_i;
              OffRentLo: rent_d[7:0]  = image_byte_i;
              OffRentHi: rent_d[15:8] = image_byte_i;
              OffScLo:   sc_d[7:0]    = image_byte_i;
              OffScHi:   sc_d[15:8]   = image_byte_i;
              OffSpfLo:  spf_d[7:0]   = image_byte_i;
              OffSpfHi:  spf_d[15:8]  = image_byte_i;
              default: ;
            endcase
          end else if (fat_ok_q && (32'(off_q) >= fat_start_q)) begin
            unique case (phase_q)
              PhFirst: begin
                held_d  = image_byte_i;
                phase_d = PhSecond;
              end
              PhSecond: begin
                ent_chk = 1'b1;
                ent_val = {image_byte_i[3:0], held_q};
                ent_idx = entry_q;
                held_d  = image_byte_i;
                phase_d = PhThird;
              end
              PhThird: begin
                ent_chk = 1'b1;
                ent_val = {image_byte_i, held_q[7:4]};
                ent_idx = entry_q + 1'b1;
                if (entry_q >= EntryLastPair) begin
                  phase_d = PhDone;
                end else begin
                  entry_d = entry_q + EntryBits'(2);
                  phase_d = PhFirst;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OpFatStart: fat_start_d = prod;
      OpRoot: begin
        root_d   = 24'(rsv_q) + prod[23:0];
        fat_ok_d = (bps_q != '0) && (fat_start_q >= 32'(FatMinOffset));
      end
      OpDivInit: begin
        div_d  = {rent_q, {RootShift{1'b0}}};
        rem_d  = '0;
        dcnt_d = DivCntW'(DivBits);
      end
      // One restoring division step per cycle
      OpDivStep: begin
        rem_d  = qbit ? 16'(trial - {1'b0, bps_q}) : trial[15:0];
        div_d  = {div_q[DivBits-2:0], qbit};
        dcnt_d = dcnt_q - 1'b1;
      end
      // Saturate the data start to 24 bits
      OpData: data_d = data_sum[24] ? '1 : data_sum[23:0];
      // Last entry index to count, clamped to the 12-bit range
      OpHi: begin
        if ({8'b0, sc_q} > data_q) begin
          hi_d = (hi_diff > 17'(EntryMax)) ? EntryMax : hi_diff[EntryBits-1:0];
        end else begin
          hi_d = EntryBits'(1);
        end
      end
      // Load the result register and start over for the next image
      OpEmit: if (go) begin
        out_valid_d = 1'b1;
        res_bytes_d = prod[27:0];
        res_free_d  = free_q;
        res_bps_d   = bps_q;
        res_root_d  = root_q;
        res_data_d  = data_q;
        res_err_d   = err;
        off_d       = '0;
        bps_d       = '0;
        rsv_d       = '0;
        nfat_d      = '0;
        rent_d      = '0;
        sc_d        = '0;
        spf_d       = '0;
        fat_ok_d    = 1'b0;
        root_d      = '0;
        data_d      = '0;
        hi_d        = '0;
        phase_d     = PhFirst;
        held_d      = '0;
        entry_d     = '0;
        free_d      = '0;
      end
      default: ;
    endcase

    // Count a free entry inside the range
    if (ent_chk && (ent_val == '0) && (ent_idx >= EntryBits'(2)) && (ent_idx <= hi_q)) begin
      free_d = free_q + 1'b1;
    end
  end

  // Control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepFetch;
      off_q       <= '0;
      bps_q       <= '0;
      rsv_q       <= '0;
      nfat_q      <= '0;
      rent_q      <= '0;
      sc_q        <= '0;
      spf_q       <= '0;
      last_q      <= 1'b0;
      fat_ok_q    <= 1'b0;
      root_q      <= '0;
      data_q      <= '0;
      hi_q        <= '0;
      phase_q     <= PhFirst;
      held_q      <= '0;
      entry_q     <= '0;
      free_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      off_q       <= off_d;
      bps_q       <= bps_d;
      rsv_q       <= rsv_d;
      nfat_q      <= nfat_d;
      rent_q      <= rent_d;
      sc_q        <= sc_d;
      spf_q       <= spf_d;
      last_q      <= last_d;
      fat_ok_q    <= fat_ok_d;
      root_q      <= root_d;
      data_q      <= data_d;
      hi_q        <= hi_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      entry_q     <= entry_d;
      free_q      <= free_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fat_start_q <= fat_start_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    res_bytes_q <= res_bytes_d;
    res_free_q  <= res_free_d;
    res_bps_q   <= res_bps_d;
    res_root_q  <= res_root_d;
    res_data_q  <= res_data_d;
    res_err_q   <= res_err_d;
  end

  assign in_ready_o          = cw.accept;
  assign out_valid_o         = out_valid_q;
  assign free_bytes_o        = res_bytes_q;
  assign free_clusters_o     = res_free_q;
  assign sector_size_o       = res_bps_q;
  assign root_start_sector_o = res_root_q;
  assign data_start_sector_o = res_data_q;
  assign geometry_error_o    = res_err_q;

  // Loading a result clears the image state
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op == OpEmit && go) |=> (out_valid_o && off_q == '0 && free_q == '0))
    else $error("result load did not restart the scan");

  // FAT scan ends only after the last entry pair
  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone) |-> (entry_q == EntryLastPair))
    else $error("FAT scan finished early");

  // Free count cannot pass the entries already seen
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= entry_q)
    else $error("free count exceeds unpacked entries");

  // Divider loop always has steps left
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == StepDivStep) |-> (dcnt_q != '0))
    else $error("divider step count ran out");

  // Input is only taken at the fetch step
  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (pc_q == StepFetch || pc_q == StepRoute))
    else $error("byte transfer left the sequencer off its path");

endmodule

`default_nettype wire

FILE: dv/fat12_free_space_scan_top_tb.sv
`timescale 1ns / 100ps

module fat12_free_space_scan_top_tb;
  import fat12fs_pkg::*;

  // One emitted scan summary, in port order
  typedef struct packed {
    logic [27:0] free_bytes;
    logic [11:0] free_clusters;
    logic [15:0] sector_size;
    logic [23:0] root_start;
    logic [23:0] data_start;
    logic        geometry_error;
  } scan_result_t;

  // How bytes outside the boot fields are filled
  typedef enum logic [1:0] {
    FillZero,
    FillOnes,
    FillMix,
    FillRandom
  } fill_e;

  // One disk image: boot fields, length, filler and an optional fixed answer
  typedef struct packed {
    logic [15:0]  bps;
    logic [15:0]  rsv;
    logic [7:0]   nfat;
    logic [15:0]  rent;
    logic [15:0]  sec_count;
    logic [15:0]  spf;
    logic [15:0]  len;
    fill_e        fill;
    logic         typed;
    scan_result_t want;
  } image_spec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  image_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [27:0] free_bytes;
  logic [11:0] free_clusters;
  logic [15:0] sector_size;
  logic [23:0] root_start_sector;
  logic [23:0] data_start_sector;
  logic        geometry_error;

  // Scanner state as the predictor tracks it
  logic [OffsetBits-1:0] scan_offset = '0;
  logic [15:0]           bpb_bps = '0;
  logic [15:0]           bpb_rsv = '0;
  logic [7:0]            bpb_nfat = '0;
  logic [15:0]           bpb_rent = '0;
  logic [15:0]           bpb_sc = '0;
  logic [15:0]           bpb_spf = '0;
  logic [23:0]           root_sec = '0;
  logic [23:0]           data_sec = '0;
  logic [11:0]           top_entry = '0;
  phase_e                pair_phase = PhFirst;
  logic [7:0]            held_byte = '0;
  logic [11:0]           pair_index = '0;
  logic [11:0]           free_tally = '0;

  scan_result_t expected_results[$];
  int unsigned  fail_count = 0;
  bit           idle_off = 1'b0;
  bit           long_hold_req = 1'b0;

  // Directed images; a fixed answer only where it is plain from the fields
  image_spec_t directed_images [12] = '{
    // image ends on its first byte
    '{16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd1, FillZero, 1'b1,
      '{28'd0, 12'd0, 16'd0, 24'd0, 24'd0, 1'b1}},
    // zero sector size
    '{16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd40, FillMix, 1'b1,
      '{28'd0, 12'd0, 16'd0, 24'd0, 24'd0, 1'b1}},
    // every byte all ones
    '{16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd30, FillOnes,
      1'b0, '0},
    // FAT starts inside the boot sector fields
    '{16'd1, 16'd10, 8'd0, 16'd0, 16'd0, 16'd0, 16'd40, FillZero, 1'b1,
      '{28'd0, 12'd0, 16'd1, 24'd10, 24'd10, 1'b1}},
    // small clean image, all entries free
    '{16'd2, 16'd12, 8'd2, 16'd1, 16'd39, 16'd1, 16'd42, FillZero, 1'b0, '0},
    // mixed entries, bytes past the counted range
    '{16'd3, 16'd8, 8'd1, 16'd3, 16'd60, 16'd2, 16'd70, FillMix, 1'b0, '0},
    // image ends inside the counted range
    '{16'd2, 16'd12, 8'd2, 16'd1, 16'd39, 16'd1, 16'd30, FillZero, 1'b0, '0},
    // sector count not above data start
    '{16'd4, 16'd6, 8'd1, 16'd0, 16'd5, 16'd1, 16'd50, FillZero, 1'b0, '0},
    // image ends before the boot fields are complete
    '{16'h0200, 16'd1, 8'd2, 16'd224, 16'd2880, 16'd9, 16'd20, FillRandom, 1'b0, '0},
    // range clipped at the last 12-bit entry index, image cut short
    '{16'd1, 16'd24, 8'd1, 16'd0, 16'hFFFF, 16'd0, 16'd96, FillZero, 1'b0, '0},
    // image ends between the bytes of an entry pair
    '{16'd1, 16'd24, 8'd0, 16'd0, 16'd100, 16'd0, 16'd26, FillZero, 1'b0, '0},
    // top bits of every field but the reserved sector count
    '{16'h8000, 16'h0000, 8'h80, 16'h8000, 16'h8000, 16'h8000, 16'd24, FillRandom,
      1'b0, '0}
  };

  fat12_free_space_scan_top dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .image_byte_i        (image_byte),
    .last_byte_i         (last_byte),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .free_bytes_o        (free_bytes),
    .free_clusters_o     (free_clusters),
    .sector_size_o       (sector_size),
    .root_start_sector_o (root_start_sector),
    .data_start_sector_o (data_start_sector),
    .geometry_error_o    (geometry_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Return the scanner to its power-up state
  function automatic void scan_clear();
    scan_offset = '0;
    bpb_bps     = '0;
    bpb_rsv     = '0;
    bpb_nfat    = '0;
    bpb_rent    = '0;
    bpb_sc      = '0;
    bpb_spf     = '0;
    root_sec    = '0;
    data_sec    = '0;
    top_entry   = '0;
    pair_phase  = PhFirst;
    held_byte   = '0;
    pair_index  = '0;
    free_tally  = '0;
  endfunction

  // Count a FAT entry when it is free and inside the counted range
  function automatic void tally_if_free(input logic [11:0] value, input int unsigned idx);
    if (value == 12'h000 && idx >= 2 && idx <= top_entry) free_tally = free_tally + 1'b1;
  endfunction

  // Advance the scanner by one image byte; on the last byte, produce the summary
  task automatic scan_step(input logic [7:0] b, input logic last, output bit has_res,
                           output scan_result_t res);
    longint unsigned fat_at;
    int unsigned     root, data, next_idx;
    logic [63:0]     prod;
    bit              err;
    has_res = 1'b0;
    res     = '0;
    fat_at  = bpb_rsv * bpb_bps;
    if (scan_offset != OffsetMax) begin
      if (scan_offset <= BootEndOffset) begin
        case (scan_offset)
          OffBpsLo:  bpb_bps[7:0]   = b;
          OffBpsHi:  bpb_bps[15:8]  = b;
          OffRsvLo:  bpb_rsv[7:0]   = b;
          OffRsvHi:  bpb_rsv[15:8]  = b;
          OffNfat:   bpb_nfat       = b;
          OffRentLo: bpb_rent[7:0]  = b;
          OffRentHi: bpb_rent[15:8] = b;
          OffScLo:   bpb_sc[7:0]    = b;
          OffScHi:   bpb_sc[15:8]   = b;
          OffSpfLo:  bpb_spf[7:0]   = b;
          OffSpfHi:  bpb_spf[15:8]  = b;
          default: ;
        endcase
        // Derive the geometry once the boot fields are complete
        if (scan_offset == BootEndOffset) begin
          root = bpb_rsv + bpb_nfat * bpb_spf;
          data = root + ((bpb_bps != 0) ? (bpb_rent * 32) / bpb_bps : 0);
          if (data > 32'hFF_FFFF) data = 32'hFF_FFFF;
          root_sec = root[23:0];
          data_sec = data[23:0];
          if (bpb_sc > data) begin
            top_entry = (bpb_sc - data + 1 > EntryMax) ? EntryMax : 12'(bpb_sc - data + 1);
          end else begin
            top_entry = 12'd1;
          end
        end
      end else if (bpb_bps != 0 && fat_at >= FatMinOffset && scan_offset >= fat_at) begin
        // Unpack two 12-bit entries from every three FAT bytes
        case (pair_phase)
          PhFirst: begin
            held_byte  = b;
            pair_phase = PhSecond;
          end
          PhSecond: begin
            tally_if_free({b[3:0], held_byte}, pair_index);
            held_byte  = b;
            pair_phase = PhThird;
          end
          PhThird: begin
            tally_if_free({b, held_byte[7:4]}, pair_index + 1);
            if (pair_index + 1 >= EntryMax) begin
              pair_phase = PhDone;
            end else begin
              pair_index = pair_index + 12'd2;
              pair_phase = PhFirst;
            end
          end
          default: ;
        endcase
      end
      scan_offset = scan_offset + 1'b1;
    end

    if (last) begin
      // Flag a missing geometry or an image that stopped short of the range
      err    = 1'b0;
      fat_at = bpb_rsv * bpb_bps;
      if (scan_offset < FatMinOffset || bpb_bps == 0 || fat_at < FatMinOffset) begin
        err = 1'b1;
      end else if (top_entry >= 2 && pair_phase != PhDone) begin
        next_idx = pair_index + ((pair_phase == PhThird) ? 1 : 0);
        if (next_idx <= top_entry) err = 1'b1;
      end
      prod                 = free_tally * bpb_bps;
      res.free_bytes       = prod[27:0];
      res.free_clusters    = free_tally;
      res.sector_size      = bpb_bps;
      res.root_start       = root_sec;
      res.data_start       = data_sec;
      res.geometry_error   = err;
      has_res              = 1'b1;
      scan_clear();
    end
  endtask

  function automatic logic [7:0] image_byte_at(input image_spec_t s, input int unsigned off);
    logic [7:0] filler;
    case (s.fill)
      FillZero: filler = 8'h00;
      FillOnes: filler = 8'hFF;
      FillMix:  filler = ($urandom_range(0, 9) < 6) ? 8'h00 : 8'($urandom);
      default:  filler = 8'($urandom);
    endcase
    case (off)
      OffBpsLo:  return s.bps[7:0];
      OffBpsHi:  return s.bps[15:8];
      OffRsvLo:  return s.rsv[7:0];
      OffRsvHi:  return s.rsv[15:8];
      OffNfat:   return s.nfat;
      OffRentLo: return s.rent[7:0];
      OffRentHi: return s.rent[15:8];
      OffScLo:   return s.sec_count[7:0];
      OffScHi:   return s.sec_count[15:8];
      OffSpfLo:  return s.spf[7:0];
      OffSpfHi:  return s.spf[15:8];
      default:   return filler;
    endcase
  endfunction

  // Mostly well-formed images with a reachable FAT; some noise, some cut short
  task automatic random_image(output image_spec_t s);
    int unsigned kind, pick, root, data, top, full;
    kind   = $urandom_range(0, 19);
    s      = '0;
    s.fill = ($urandom_range(0, 3) == 0) ? FillRandom : FillMix;
    if (kind < 2) begin
      s.bps       = 16'($urandom);
      s.rsv       = 16'($urandom);
      s.nfat      = 8'($urandom);
      s.rent      = 16'($urandom);
      s.sec_count = 16'($urandom);
      s.spf       = 16'($urandom);
      s.len       = 16'($urandom_range(1, 60));
      s.fill      = FillRandom;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 14) s.bps = 16'($urandom_range(1, 4));
      else if (pick < 18) s.bps = 16'($urandom_range(5, 16));
      else s.bps = 16'($urandom_range(17, 64));
      s.rsv  = 16'((24 + s.bps - 1) / s.bps + ((s.bps <= 16) ? $urandom_range(0, 2) : 0));
      s.nfat = 8'($urandom_range(0, 3));
      s.spf  = 16'($urandom_range(0, 8));
      s.rent = 16'($urandom_range(0, 48));
      root   = s.rsv + s.nfat * s.spf;
      data   = root + (s.rent * 32) / s.bps;
      if (kind < 4) s.sec_count = 16'($urandom_range(0, data));
      else s.sec_count = 16'(data + $urandom_range(0, 24));
      top   = (s.sec_count > data) ? s.sec_count - data + 1 : 1;
      full  = s.rsv * s.bps + (top / 2 + 1) * 3 + $urandom_range(0, 4);
      s.len = 16'((kind < 6) ? $urandom_range(1, full) : full);
      if (kind == 6) s.bps = '0;
    end
  endtask

  // Offer one byte, hold it until the transfer, then predict its effect
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input scan_result_t want);
    scan_result_t res;
    bit           has_res;
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    image_byte <= b;
    last_byte  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_step(b, last, has_res, res);
    if (has_res) expected_results.push_back(typed ? want : res);
  endtask

  task automatic send_image(input image_spec_t s);
    for (int unsigned off = 0; off < s.len; off++) begin
      send_byte(image_byte_at(s, off), off == s.len - 1, s.typed, s.want);
    end
  endtask

  // Drop valid and hold until every expected summary has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic check_result();
    scan_result_t got, want;
    got = '{free_bytes, free_clusters, sector_size, root_start_sector, data_start_sector,
            geometry_error};
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected summary: bytes=%0d clusters=%0d size=%0d err=%0b",
                 got.free_bytes, got.free_clusters, got.sector_size, got.geometry_error);
    end else begin
      want = expected_results.pop_front();
      if (got.free_bytes !== want.free_bytes || got.free_clusters !== want.free_clusters ||
          got.sector_size !== want.sector_size || got.root_start !== want.root_start ||
          got.data_start !== want.data_start ||
          got.geometry_error !== want.geometry_error) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: exp bytes=%0d clusters=%0d size=%0d root=%0d data=%0d err=%0b",
                   want.free_bytes, want.free_clusters, want.sector_size, want.root_start,
                   want.data_start, want.geometry_error);
          $display("          got bytes=%0d clusters=%0d size=%0d root=%0d data=%0d err=%0b",
                   got.free_bytes, got.free_clusters, got.sector_size, got.root_start,
                   got.data_start, got.geometry_error);
        end
      end
    end
  endtask

  // Take summaries, stall in short bursts, and hold off for long on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result();
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 400;
      end else if (stall_left == 0 && !idle_off && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : image_source
    image_spec_t spec;
    int unsigned rand_bytes, rand_images;
    bit          paused;
    rand_bytes  = 0;
    rand_images = 0;
    paused      = 1'b0;
    scan_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed images
    foreach (directed_images[i]) send_image(directed_images[i]);
    drain_results();

    // Random images; the sink holds off at the start so the block backs up
    long_hold_req = 1'b1;
    while (rand_bytes < 1180 || rand_images < 25) begin
      random_image(spec);
      spec.typed = 1'b0;
      send_image(spec);
      rand_bytes += spec.len;
      rand_images++;
      if (!paused && rand_bytes >= 600) begin
        paused = 1'b1;
        drain_results();
      end
      if (rand_bytes >= 900) idle_off = 1'b1;
    end

    // Let the last summaries arrive, then give the verdict
    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
